>>> rtl/core/vna_pkg.sv
package vna_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);

  localparam int POS_W  = 24;
  localparam int SUM_W  = 24;
  localparam int NRM_W  = 16;
  localparam int ROW_W  = 3 * POS_W;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FACE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh800000;
  localparam logic signed [NRM_W-1:0] UNIT_ONE = 16'sd16384;

  typedef logic [ROW_W-1:0] row_t;

endpackage

>>> rtl/core/vertex_normal_accumulator.sv
// Smooth vertex normal accumulator.
// Input words (in_valid/in_stall) carry one of three actions:
//   load: stores a Q11.12 position and clears that vertex's normal sum;
//         gives no result.
//   face: reads the three corner positions, forms the unit cross product
//         (b-a) x (c-a) in Q1.14 and adds it, saturating, to the sums of
//         corners a, b and c unless it is zero; gives no result.
//   read: gives one result word (out_valid/out_stall) with the normalized
//         sum in Q1.14, or zero with out_zero_length set.
// One item is worked at a time; in_stall is high while an item is busy.
// A face or a read runs the one-bit normalizing shift loop, the 32-step
// square root and the 15-step divider, which runs three times per vector.
// Position and sum memories are single synchronous RAMs.
// A result waits in the output register while out_stall is high; a
// following read item stalls at its last step until the register frees.
// Reset returns the control to idle; memory contents stay undefined until
// each vertex is loaded.
module vertex_normal_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [9:0]                  in_vertex_index,
  input  logic signed [23:0]          in_pos_x,
  input  logic signed [23:0]          in_pos_y,
  input  logic signed [23:0]          in_pos_z,
  input  logic [9:0]                  in_corner_a,
  input  logic [9:0]                  in_corner_b,
  input  logic [9:0]                  in_corner_c,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_normal_x,
  output logic signed [15:0]          out_normal_y,
  output logic signed [15:0]          out_normal_z,
  output logic                        out_zero_length
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_F_RA   = 4'd1;
  localparam logic [3:0] ST_F_RB   = 4'd2;
  localparam logic [3:0] ST_F_RC   = 4'd3;
  localparam logic [3:0] ST_F_EDGE = 4'd4;
  localparam logic [3:0] ST_F_MUL  = 4'd5;
  localparam logic [3:0] ST_R_RD   = 4'd6;
  localparam logic [3:0] ST_N_LOAD = 4'd7;
  localparam logic [3:0] ST_N_SHFT = 4'd8;
  localparam logic [3:0] ST_N_SQ   = 4'd9;
  localparam logic [3:0] ST_N_SQRT = 4'd10;
  localparam logic [3:0] ST_N_DIV  = 4'd11;
  localparam logic [3:0] ST_F_SRD  = 4'd12;
  localparam logic [3:0] ST_F_SWR  = 4'd13;
  localparam logic [3:0] ST_R_OUT  = 4'd14;

  localparam int AW = vna_pkg::ADDR_W;

  // memories
  vna_pkg::row_t pos_mem [vna_pkg::VERTEX_DEPTH];
  vna_pkg::row_t sum_mem [vna_pkg::VERTEX_DEPTH];
  vna_pkg::row_t pos_q;
  vna_pkg::row_t sum_q;
  logic [AW-1:0] pos_raddr;
  logic [AW-1:0] sum_raddr;
  logic          pos_we;
  logic          sum_we;
  logic [AW-1:0] sum_waddr;
  vna_pkg::row_t sum_wdata;

  logic [3:0]    state_r;
  logic          face_r;
  logic          in_acc;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] ca_r, cb_r, cc_r;
  vna_pkg::row_t pa_r, pb_r;
  logic signed [24:0] e0_r [3];
  logic signed [24:0] e1_r [3];
  logic [2:0]         mstep_r;
  logic [2:0]         mk;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r;
  logic signed [50:0] cr_r [3];
  logic signed [50:0] src [3];
  logic [51:0]        m_r [3];
  logic               neg_r [3];
  logic               src_zero;
  logic               any_hi, all_lo;
  logic [1:0]         sqc_r;
  logic [29:0]        sq_in;
  logic [59:0]        sq_r;
  logic [61:0]        len2_r;
  logic [63:0]        sx_r, sres_r, sbit_r, strial;
  logic [30:0]        root_r;
  logic [1:0]         dc_r;
  logic [3:0]         dq_r;
  logic               dstart_r;
  logic [45:0]        rem_r, dv_r;
  logic [14:0]        q_r, q_fin;
  logic               q_ge;
  logic [29:0]        dm;
  logic               dneg;
  logic signed [15:0] nout_r [3];
  logic               zl_r;
  logic [1:0]         cj_r;
  logic [AW-1:0]      cj_addr;
  logic               out_free;
  logic               in_range;
  logic               face_range;

  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic               out_zl_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_range   = 32'(in_vertex_index) < vna_pkg::VERTEX_DEPTH;
  assign face_range = (32'(in_corner_a) < vna_pkg::VERTEX_DEPTH)
                   && (32'(in_corner_b) < vna_pkg::VERTEX_DEPTH)
                   && (32'(in_corner_c) < vna_pkg::VERTEX_DEPTH);

  assign pos_we = in_acc && (in_action == vna_pkg::ACT_LOAD) && in_range;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[in_vertex_index[AW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  always_comb begin
    unique case (state_r)
      ST_F_RB: pos_raddr = cb_r;
      ST_F_RC: pos_raddr = cc_r;
      default: pos_raddr = ca_r;
    endcase
  end

  always_comb begin
    unique case (cj_r)
      2'd1:    cj_addr = cb_r;
      2'd2:    cj_addr = cc_r;
      default: cj_addr = ca_r;
    endcase
  end

  assign sum_raddr = (state_r == ST_R_RD) ? idx_r : cj_addr;

  // saturating add of the face normal into the fetched sum
  function automatic logic signed [23:0] sat_add(input logic signed [23:0] s,
                                                 input logic signed [15:0] d);
    logic signed [24:0] t;
    t = 25'(s) + 25'(d);
    if (t[24] != t[23]) begin
      return t[24] ? vna_pkg::SUM_MIN : vna_pkg::SUM_MAX;
    end
    return t[23:0];
  endfunction

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = cj_addr;
    sum_wdata = '0;
    if (pos_we) begin
      sum_we    = 1'b1;
      sum_waddr = in_vertex_index[AW-1:0];
    end else if (state_r == ST_F_SWR) begin
      sum_we    = 1'b1;
      sum_wdata = {sat_add(sum_q[71:48], nout_r[0]),
                   sat_add(sum_q[47:24], nout_r[1]),
                   sat_add(sum_q[23:0],  nout_r[2])};
    end
  end

  // cross product operand select
  always_comb begin
    unique case (mstep_r)
      3'd0:    begin mul_a = e0_r[1]; mul_b = e1_r[2]; end
      3'd1:    begin mul_a = e0_r[2]; mul_b = e1_r[1]; end
      3'd2:    begin mul_a = e0_r[2]; mul_b = e1_r[0]; end
      3'd3:    begin mul_a = e0_r[0]; mul_b = e1_r[2]; end
      3'd4:    begin mul_a = e0_r[0]; mul_b = e1_r[1]; end
      3'd5:    begin mul_a = e0_r[1]; mul_b = e1_r[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end
  assign mk = mstep_r - 3'd1;

  // vector to normalize: cross product for a face, stored sum for a read
  assign src[0] = face_r ? cr_r[0] : 51'(signed'(sum_q[71:48]));
  assign src[1] = face_r ? cr_r[1] : 51'(signed'(sum_q[47:24]));
  assign src[2] = face_r ? cr_r[2] : 51'(signed'(sum_q[23:0]));
  assign src_zero = (src[0] == '0) && (src[1] == '0) && (src[2] == '0);

  assign any_hi = (|m_r[0][51:30]) || (|m_r[1][51:30]) || (|m_r[2][51:30]);
  assign all_lo = !((|m_r[0][51:29]) || (|m_r[1][51:29]) || (|m_r[2][51:29]));

  always_comb begin
    unique case (sqc_r)
      2'd1:    sq_in = m_r[1][29:0];
      2'd2:    sq_in = m_r[2][29:0];
      default: sq_in = m_r[0][29:0];
    endcase
  end

  always_comb begin
    unique case (dc_r)
      2'd1:    begin dm = m_r[1][29:0]; dneg = neg_r[1]; end
      2'd2:    begin dm = m_r[2][29:0]; dneg = neg_r[2]; end
      default: begin dm = m_r[0][29:0]; dneg = neg_r[0]; end
    endcase
  end

  assign strial = sres_r + sbit_r;
  assign q_ge   = (rem_r >= dv_r);
  assign q_fin  = {q_r[13:0], q_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (out_valid_r && !out_stall && state_r != ST_R_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            idx_r <= in_vertex_index[AW-1:0];
            ca_r  <= in_corner_a[AW-1:0];
            cb_r  <= in_corner_b[AW-1:0];
            cc_r  <= in_corner_c[AW-1:0];
            priority if (in_action == vna_pkg::ACT_FACE && face_range) begin
              face_r  <= 1'b1;
              state_r <= ST_F_RA;
            end else if (in_action == vna_pkg::ACT_READ && in_range) begin
              face_r  <= 1'b0;
              state_r <= ST_R_RD;
            end else if (in_action == vna_pkg::ACT_READ) begin
              nout_r[0] <= '0;
              nout_r[1] <= '0;
              nout_r[2] <= '0;
              zl_r      <= 1'b1;
              state_r   <= ST_R_OUT;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_F_RA: state_r <= ST_F_RB;
        ST_F_RB: begin
          pa_r    <= pos_q;
          state_r <= ST_F_RC;
        end
        ST_F_RC: begin
          pb_r    <= pos_q;
          state_r <= ST_F_EDGE;
        end
        ST_F_EDGE: begin
          e0_r[0] <= 25'(signed'(pb_r[71:48])) - 25'(signed'(pa_r[71:48]));
          e0_r[1] <= 25'(signed'(pb_r[47:24])) - 25'(signed'(pa_r[47:24]));
          e0_r[2] <= 25'(signed'(pb_r[23:0]))  - 25'(signed'(pa_r[23:0]));
          e1_r[0] <= 25'(signed'(pos_q[71:48])) - 25'(signed'(pa_r[71:48]));
          e1_r[1] <= 25'(signed'(pos_q[47:24])) - 25'(signed'(pa_r[47:24]));
          e1_r[2] <= 25'(signed'(pos_q[23:0]))  - 25'(signed'(pa_r[23:0]));
          mstep_r <= '0;
          state_r <= ST_F_MUL;
        end
        ST_F_MUL: begin
          // one product per cycle; fold the previous one into the cross term
          prod_r <= mul_a * mul_b;
          if (mstep_r != 3'd0) begin
            if (mk[0]) begin
              cr_r[mk[2:1]] <= cr_r[mk[2:1]] - 51'(prod_r);
            end else begin
              cr_r[mk[2:1]] <= 51'(prod_r);
            end
          end
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd6) begin
            state_r <= ST_N_LOAD;
          end
        end
        ST_R_RD: state_r <= ST_N_LOAD;
        ST_N_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= src[i][50];
            m_r[i]   <= {1'b0, src[i][50] ? 51'(-src[i]) : 51'(src[i])};
          end
          if (src_zero) begin
            nout_r[0] <= '0;
            nout_r[1] <= '0;
            nout_r[2] <= '0;
            zl_r      <= 1'b1;
            state_r   <= face_r ? ST_IDLE : ST_R_OUT;
          end else begin
            zl_r    <= 1'b0;
            state_r <= ST_N_SHFT;
          end
        end
        ST_N_SHFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          priority if (any_hi) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (all_lo) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            sqc_r   <= '0;
            len2_r  <= '0;
            state_r <= ST_N_SQ;
          end
        end
        ST_N_SQ: begin
          sq_r  <= sq_in * sq_in;
          sqc_r <= sqc_r + 2'd1;
          if (sqc_r != 2'd0) begin
            len2_r <= len2_r + 62'(sq_r);
          end
          if (sqc_r == 2'd3) begin
            sx_r    <= 64'(len2_r) + 64'(sq_r);
            sres_r  <= '0;
            sbit_r  <= 64'd1 << 62;
            state_r <= ST_N_SQRT;
          end
        end
        ST_N_SQRT: begin
          if (sbit_r == '0) begin
            root_r   <= sres_r[30:0];
            dc_r     <= '0;
            dstart_r <= 1'b1;
            state_r  <= ST_N_DIV;
          end else begin
            if (sx_r >= strial) begin
              sx_r   <= sx_r - strial;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        ST_N_DIV: begin
          if (dstart_r) begin
            rem_r    <= {2'b0, dm, 14'b0} + 46'(root_r >> 1);
            dv_r     <= {1'b0, root_r, 14'b0};
            q_r      <= '0;
            dq_r     <= 4'd14;
            dstart_r <= 1'b0;
          end else begin
            if (q_ge) begin
              rem_r <= rem_r - dv_r;
            end
            dv_r <= dv_r >> 1;
            q_r  <= q_fin;
            dq_r <= dq_r - 4'd1;
            if (dq_r == 4'd0) begin
              nout_r[dc_r] <= dneg ? -16'(signed'({1'b0, q_fin}))
                                   : 16'(signed'({1'b0, q_fin}));
              dstart_r <= 1'b1;
              dc_r     <= dc_r + 2'd1;
              if (dc_r == 2'd2) begin
                cj_r    <= '0;
                state_r <= face_r ? ST_F_SRD : ST_R_OUT;
              end
            end
          end
        end
        ST_F_SRD: state_r <= ST_F_SWR;
        ST_F_SWR: begin
          // write back before the next corner is read, so repeated corners see it
          cj_r    <= cj_r + 2'd1;
          state_r <= (cj_r == 2'd2) ? ST_IDLE : ST_F_SRD;
        end
        ST_R_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= nout_r[0];
            out_y_r     <= nout_r[1];
            out_z_r     <= nout_r[2];
            out_zl_r    <= zl_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_x_r;
  assign out_normal_y    = out_y_r;
  assign out_normal_z    = out_z_r;
  assign out_zero_length = out_zl_r;

`ifndef SYNTHESIS
  a_sum_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    sum_we |-> (state_r == ST_IDLE || state_r == ST_F_SWR))
    else $error("sum memory written outside load or write-back");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_R_OUT)
    else $error("result raised outside output step");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= vna_pkg::UNIT_ONE && out_x_r >= -vna_pkg::UNIT_ONE
                  && out_y_r <= vna_pkg::UNIT_ONE && out_y_r >= -vna_pkg::UNIT_ONE
                  && out_z_r <= vna_pkg::UNIT_ONE && out_z_r >= -vna_pkg::UNIT_ONE))
    else $error("normal component beyond unit range");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zl_r) |-> (out_x_r == '0 && out_y_r == '0 && out_z_r == '0))
    else $error("zero-length result with nonzero normal");
`endif

endmodule
